@@ hw/rtl/bpa_pkg.sv @@
package bpa_pkg;

   localparam int KIND_W      = 2;
   localparam int ADDR_W      = 27;
   localparam int COUNT_W     = 16;
   localparam int CFG_W       = 16;
   localparam int WORD_BITS   = 32;
   localparam int WORD_SHIFT  = 5;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

   localparam logic [CFG_W-1:0] PAGES_PRESENT_RESET = 16'd32768;

   typedef struct packed {
      logic clear;
      logic load;
      logic scan_init;
      logic scan;
      logic mark_init;
      logic mark_rd;
      logic mark_wr;
      logic oom;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic              clear_last;
      logic [KIND_W-1:0] kind;
      logic              alloc_none;
      logic              mark_empty;
      logic              found;
      logic              fail;
      logic              mark_last;
      logic              rsp_busy;
   } dp_stat_type;

endpackage

@@ hw/rtl/bitmap_page_allocator_core.sv @@
// First-fit physical page allocator over a used-page bitmap held in an on-chip memory of
// PAGE_COUNT_MAX/32 words. After reset the block sweeps the bitmap once, one word per cycle,
// setting every page used; req_tready stays low until that is done, while csr writes are
// taken at once. Items are handled one at a time. Allocate scans the bitmap one 32-page
// word at a time until the run is found (at most the words covering the pages below
// min(pages_present, PAGE_COUNT_MAX)), then reads and writes back each word of the run it
// marks. Free and reserve read and write back each word they touch. A finished result
// waits in an output register, so the next item is accepted while it is pending. Write
// pages_present only while the block is idle.
module bitmap_page_allocator_core #(
   parameter int PAGE_COUNT_MAX = 32768,
   parameter int PAGE_BYTES     = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpa_pkg::CFG_W-1:0]          csr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // page_address [26:0], page_count [42:27], zero [47:43]
   input  logic [bpa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // kind [1:0]
   input  logic [bpa_pkg::KIND_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // block_address [26:0], zero [31:27]
   output logic [bpa_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status [0]
   output logic [0:0]                         rsp_tuser
);
   import bpa_pkg::*;

   ctl_cmd_type       cmd;
   dp_stat_type       st;
   logic [ADDR_W-1:0] block_address;
   logic              status;

   bpa_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bpa_datapath #(
      .PAGE_COUNT_MAX (PAGE_COUNT_MAX),
      .PAGE_BYTES     (PAGE_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_kind          (req_tuser),
      .req_page_address  (req_tdata[ADDR_W-1:0]),
      .req_page_count    (req_tdata[ADDR_W+COUNT_W-1:ADDR_W]),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_block_address (block_address),
      .rsp_status        (status)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - ADDR_W){1'b0}}, block_address};
   assign rsp_tuser = status;

endmodule

@@ hw/rtl/bpa_datapath.sv @@
module bpa_datapath #(
   parameter int PAGE_COUNT_MAX = 32768,
   parameter int PAGE_BYTES     = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bpa_pkg::ctl_cmd_type                cmd,
   output bpa_pkg::dp_stat_type                st,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpa_pkg::CFG_W-1:0]           csr_data,
   input  logic [bpa_pkg::KIND_W-1:0]          req_kind,
   input  logic [bpa_pkg::ADDR_W-1:0]          req_page_address,
   input  logic [bpa_pkg::COUNT_W-1:0]         req_page_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bpa_pkg::ADDR_W-1:0]          rsp_block_address,
   output logic                                rsp_status
);
   import bpa_pkg::*;

   localparam int MAP_WORDS = (PAGE_COUNT_MAX + WORD_BITS - 1) / WORD_BITS;
   localparam int WW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IW   = WW + WORD_SHIFT;
   localparam int OFS  = $clog2(PAGE_BYTES);
   localparam int FPW  = ADDR_W - OFS;
   localparam int PW   = $clog2(PAGE_COUNT_MAX + 1);
   localparam int EW_A = (IW + 1 > PW) ? IW + 1 : PW;
   localparam int EW_B = (EW_A > FPW) ? EW_A : FPW;
   localparam int EW   = (EW_B > COUNT_W + 1) ? EW_B + 1 : COUNT_W + 2;
   localparam int RW   = COUNT_W + 1;
   localparam int TW   = WORD_SHIFT + 1;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] map_rd_ff;

   logic [CFG_W-1:0]   pages_present_ff, pages_present_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [EW-1:0]      limit_ff, limit_in;
   logic [EW-1:0]      lo_ff, lo_in;
   logic [EW-1:0]      hi_ff, hi_in;
   logic               set_ff, set_in;
   logic [WW-1:0]      widx_ff, widx_in;
   logic [WW-1:0]      clr_addr_ff, clr_addr_in;
   logic [WW-1:0]      scan_addr_ff, scan_addr_in;
   logic               scan_more_ff, scan_more_in;
   logic               eval_valid_ff, eval_valid_in;
   logic [WW-1:0]      eval_word_ff, eval_word_in;
   logic [RW-1:0]      run_ff, run_in;
   logic [EW-1:0]      start_ff, start_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               res_oom_ff, res_oom_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic               rsp_oom_ff, rsp_oom_in;

   logic [EW-1:0]      present_ext, limit_w, first_ext, req_end, hi_m1, lim_m1;
   logic [WW-1:0]      scan_last, mark_last_w;
   logic [EW-1:0]      base_page, mark_base;
   logic [WORD_BITS-1:0] avail_mask, free_bits, mark_mask, mark_data;
   logic [WORD_BITS-1:0] runs_pow [6];
   logic [WORD_BITS-1:0] run_hits;
   logic [TW-1:0]      low_free, high_free, hit_pos;
   logic [TW-1:0]      shift_acc;
   logic               all_free, fits, cont, hit;
   logic [EW-1:0]      cont_start, found_start;
   logic [RW-1:0]      run_next;
   logic [EW-1:0]      start_next;
   logic [EW+OFS-1:0]  found_shift;
   logic               mem_we, mem_re;
   logic [WW-1:0]      wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data;

   assign present_ext = EW'(pages_present_ff);
   assign limit_w     = (present_ext > EW'(PAGE_COUNT_MAX)) ? EW'(PAGE_COUNT_MAX) : present_ext;
   assign first_ext   = EW'(req_page_address[ADDR_W-1:OFS]);
   assign req_end     = first_ext + EW'(req_page_count);
   assign hi_m1       = hi_ff - EW'(1);
   assign lim_m1      = limit_ff - EW'(1);
   assign scan_last   = lim_m1[IW-1:WORD_SHIFT];
   assign mark_last_w = hi_m1[IW-1:WORD_SHIFT];
   assign base_page   = EW'({eval_word_ff, {WORD_SHIFT{1'b0}}});
   assign mark_base   = EW'({widx_ff, {WORD_SHIFT{1'b0}}});

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         avail_mask[i] = (base_page + EW'(i) != '0) && (base_page + EW'(i) < limit_ff);
         mark_mask[i]  = (mark_base + EW'(i) >= lo_ff) && (mark_base + EW'(i) < hi_ff);
      end
   end

   assign free_bits = ~map_rd_ff & avail_mask;
   assign all_free  = &free_bits;
   assign mark_data = (map_rd_ff & ~mark_mask) | (set_ff ? mark_mask : '0);

   always_comb begin
      low_free  = TW'(WORD_BITS);
      high_free = TW'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!free_bits[i]) begin
            low_free = TW'(i);
         end
      end
      for (int i = 0; i < WORD_BITS; i++) begin
         if (!free_bits[i]) begin
            high_free = TW'(WORD_BITS - 1 - i);
         end
      end
   end

   always_comb begin
      runs_pow[0] = free_bits;
      for (int k = 1; k < 6; k++) begin
         runs_pow[k] = runs_pow[k-1] & (runs_pow[k-1] >> (1 << (k - 1)));
      end
   end

   always_comb begin
      run_hits  = '1;
      shift_acc = '0;
      for (int k = 5; k >= 0; k--) begin
         if (count_ff[k]) begin
            run_hits  = run_hits & (runs_pow[k] >> shift_acc);
            shift_acc = shift_acc + TW'(1 << k);
         end
      end
      hit_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (run_hits[i]) begin
            hit_pos = TW'(i);
         end
      end
   end

   assign fits        = (|run_hits) && (count_ff <= COUNT_W'(WORD_BITS)) && (count_ff != '0);
   assign cont        = (run_ff + RW'(low_free)) >= RW'(count_ff);
   assign cont_start  = (run_ff == '0) ? base_page : start_ff;
   assign hit         = cont || fits;
   assign found_start = cont ? cont_start : base_page + EW'(hit_pos);
   assign run_next    = all_free ? run_ff + RW'(WORD_BITS) : RW'(high_free);
   assign start_next  = all_free ? cont_start
                                 : base_page + EW'(WORD_BITS) - EW'(high_free);
   assign found_shift = {found_start, {OFS{1'b0}}};

   assign mem_we  = cmd.clear || cmd.mark_wr;
   assign wr_addr = cmd.clear ? clr_addr_ff : widx_ff;
   assign wr_data = cmd.clear ? '1 : mark_data;
   assign mem_re  = (cmd.scan && scan_more_ff) || cmd.mark_rd;
   assign rd_addr = cmd.mark_rd ? widx_ff : scan_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         map_rd_ff <= map_mem[rd_addr];
      end
   end

   always_comb begin
      pages_present_in = pages_present_ff;
      kind_in          = kind_ff;
      count_in         = count_ff;
      limit_in         = limit_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      set_in           = set_ff;
      widx_in          = widx_ff;
      clr_addr_in      = clr_addr_ff;
      scan_addr_in     = scan_addr_ff;
      scan_more_in     = scan_more_ff;
      eval_valid_in    = eval_valid_ff;
      eval_word_in     = eval_word_ff;
      run_in           = run_ff;
      start_in         = start_ff;
      res_addr_in      = res_addr_ff;
      res_oom_in       = res_oom_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_addr_in      = rsp_addr_ff;
      rsp_oom_in       = rsp_oom_ff;

      if (csr_valid) begin
         pages_present_in = csr_data;
      end
      if (cmd.clear) begin
         clr_addr_in = clr_addr_ff + WW'(1);
      end
      if (cmd.load) begin
         kind_in     = req_kind;
         count_in    = req_page_count;
         limit_in    = limit_w;
         lo_in       = first_ext;
         hi_in       = (req_end < limit_w) ? req_end : limit_w;
         set_in      = (req_kind == KIND_RESERVE);
         res_addr_in = '0;
         res_oom_in  = 1'b0;
      end
      if (cmd.mark_init) begin
         widx_in = lo_ff[IW-1:WORD_SHIFT];
      end
      if (cmd.scan_init) begin
         scan_addr_in  = '0;
         scan_more_in  = 1'b1;
         eval_valid_in = 1'b0;
         run_in        = '0;
         start_in      = '0;
      end
      if (cmd.scan) begin
         eval_valid_in = scan_more_ff;
         eval_word_in  = scan_addr_ff;
         if (scan_more_ff) begin
            if (scan_addr_ff == scan_last) begin
               scan_more_in = 1'b0;
            end else begin
               scan_addr_in = scan_addr_ff + WW'(1);
            end
         end
         if (eval_valid_ff) begin
            if (hit) begin
               lo_in       = found_start;
               hi_in       = found_start + EW'(count_ff);
               set_in      = 1'b1;
               widx_in     = found_start[IW-1:WORD_SHIFT];
               res_addr_in = found_shift[ADDR_W-1:0];
            end else begin
               run_in   = run_next;
               start_in = start_next;
            end
         end
      end
      if (cmd.mark_wr) begin
         widx_in = widx_ff + WW'(1);
      end
      if (cmd.oom) begin
         res_oom_in = 1'b1;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res_addr_ff;
         rsp_oom_in   = res_oom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_present_ff <= PAGES_PRESENT_RESET;
         clr_addr_ff      <= '0;
         scan_more_ff     <= 1'b0;
         eval_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pages_present_ff <= pages_present_in;
         clr_addr_ff      <= clr_addr_in;
         scan_more_ff     <= scan_more_in;
         eval_valid_ff    <= eval_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      count_ff     <= count_in;
      limit_ff     <= limit_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      set_ff       <= set_in;
      widx_ff      <= widx_in;
      scan_addr_ff <= scan_addr_in;
      eval_word_ff <= eval_word_in;
      run_ff       <= run_in;
      start_ff     <= start_in;
      res_addr_ff  <= res_addr_in;
      res_oom_ff   <= res_oom_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_oom_ff   <= rsp_oom_in;
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_oom_ff;

   assign st.clear_last = (clr_addr_ff == WW'(MAP_WORDS - 1));
   assign st.kind       = kind_ff;
   assign st.alloc_none = (count_ff == '0) || (limit_ff < EW'(2));
   assign st.mark_empty = (lo_ff >= hi_ff);
   assign st.found      = eval_valid_ff && hit;
   assign st.fail       = eval_valid_ff && !hit && (eval_word_ff == scan_last);
   assign st.mark_last  = (widx_ff == mark_last_w);
   assign st.rsp_busy   = rsp_valid_ff && !rsp_ready;

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && st.found) |->
         (found_start != '0) && (found_start + EW'(count_ff) <= limit_ff))
      else $error("allocated run outside the searchable pages");

   a_oom_zero_addr: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff && (!rsp_oom_ff || (rsp_addr_ff == '0)))
      else $error("out-of-memory item carries a nonzero address");

endmodule

@@ hw/rtl/bpa_controller.sv @@
module bpa_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bpa_pkg::dp_stat_type st,
   output bpa_pkg::ctl_cmd_type cmd
);
   import bpa_pkg::*;

   typedef enum logic [6:0] {
      ST_INIT    = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_DECODE  = 7'b0000100,
      ST_SCAN    = 7'b0001000,
      ST_MARK_RD = 7'b0010000,
      ST_MARK_WR = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.clear = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (st.kind)
               KIND_ALLOC: begin
                  if (st.alloc_none) begin
                     cmd.oom  = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
               KIND_FREE, KIND_RESERVE: begin
                  if (st.mark_empty) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.mark_init = 1'b1;
                     state_in      = ST_MARK_RD;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (st.found) begin
               state_in = ST_MARK_RD;
            end else if (st.fail) begin
               cmd.oom  = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_MARK_RD: begin
            cmd.mark_rd = 1'b1;
            state_in    = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            state_in    = st.mark_last ? ST_FINISH : ST_MARK_RD;
         end
         ST_FINISH: begin
            if (!st.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DECODE))
      else $error("accepted item not decoded");

   a_found_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && st.found) |=> (state_ff == ST_MARK_RD))
      else $error("found run not marked");

endmodule

@@ sim/bitmap_page_allocator_core_tb.sv @@
module bitmap_page_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpa_pkg::*;

   localparam int PAGE_TOTAL      = 32768;
   localparam int BYTES_PER_PAGE  = 4096;
   localparam int PAGE_SHIFT      = $clog2(BYTES_PER_PAGE);
   localparam int PHASES          = 16;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int DIR_ROWS        = 28;
   localparam int REPORT_MAX      = 10;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   typedef enum logic [1:0] {ROW_CFG, ROW_TYPED, ROW_PREDICTED} row_kind_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] count;
   } page_req_type;

   typedef struct {
      logic [ADDR_W-1:0] block_address;
      logic              status;
   } page_rsp_type;

   typedef struct {
      row_kind_type       what;
      logic [CFG_W-1:0]   cfg;
      logic [KIND_W-1:0]  kind;
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] count;
      logic [ADDR_W-1:0]  exp_addr;
      logic               exp_status;
   } dir_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_data   = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;

   bit               page_used [PAGE_TOTAL];
   logic [CFG_W-1:0] pages_present_q = PAGES_PRESENT_RESET;
   page_rsp_type     pending_rsp_q [$];
   page_req_type     live_blocks_q [$];
   int unsigned      sender_idle_pct    = 0;
   int unsigned      receiver_stall_pct = 0;
   int unsigned      hold_request       = 0;
   int unsigned      hold_left          = 0;
   int unsigned      mismatch_count     = 0;
   int unsigned      result_count       = 0;
   page_rsp_type     got_want;

   dir_row_type directed_rows [DIR_ROWS] = '{
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'h0000, 27'h0000000, 1'b1},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h7FFFFFF, 16'h0000, 27'h0000000, 1'b1},
      '{ROW_TYPED,     16'h0000, KIND_FREE,    27'h0000000, 16'h0000, 27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_NONE,    27'h7FFFFFF, 16'hFFFF, 27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_FREE,    27'h0000000, 16'd16,   27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'd1,    27'h0001000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'd15,   27'h0000000, 1'b1},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'd14,   27'h0002000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_RESERVE, 27'h0000FFF, 16'd1,    27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_FREE,    27'h7FFF000, 16'd16,   27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'd1,    27'h7FFF000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_FREE,    27'h7FFFFFF, 16'hFFFF, 27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_FREE,    27'h0000000, 16'hFFFF, 27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'hFFFF, 27'h0000000, 1'b1},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'h7FFF, 27'h0001000, 1'b0},
      '{ROW_PREDICTED, 16'h0000, KIND_RESERVE, 27'h0001234, 16'd3,    27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_FREE,    27'h0000000, 16'h8000, 27'h0000000, 1'b0},
      '{ROW_CFG,       16'h0000, KIND_ALLOC,   27'h0000000, 16'h0000, 27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'd1,    27'h0000000, 1'b1},
      '{ROW_TYPED,     16'h0000, KIND_RESERVE, 27'h0000000, 16'hFFFF, 27'h0000000, 1'b0},
      '{ROW_CFG,       16'd1,    KIND_ALLOC,   27'h0000000, 16'h0000, 27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'd1,    27'h0000000, 1'b1},
      '{ROW_CFG,       16'd2,    KIND_ALLOC,   27'h0000000, 16'h0000, 27'h0000000, 1'b0},
      '{ROW_TYPED,     16'h0000, KIND_ALLOC,   27'h0000000, 16'd1,    27'h0001000, 1'b0},
      '{ROW_CFG,       16'hFFFF, KIND_ALLOC,   27'h0000000, 16'h0000, 27'h0000000, 1'b0},
      '{ROW_PREDICTED, 16'h0000, KIND_ALLOC,   27'h0000000, 16'd2,    27'h0000000, 1'b0},
      '{ROW_PREDICTED, 16'h0000, KIND_ALLOC,   27'h0000000, 16'd32766, 27'h0000000, 1'b0},
      '{ROW_PREDICTED, 16'h0000, KIND_ALLOC,   27'h0000000, 16'd1,    27'h0000000, 1'b0}
   };

   bitmap_page_allocator_core #(
      .PAGE_COUNT_MAX(PAGE_TOTAL),
      .PAGE_BYTES    (BYTES_PER_PAGE)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pages_in_use_range();
      return (pages_present_q > PAGE_TOTAL) ? PAGE_TOTAL : int'(pages_present_q);
   endfunction

   function automatic page_rsp_type predict_page_op(page_req_type it);
      int unsigned  lim;
      int unsigned  p;
      int unsigned  run;
      int unsigned  start;
      int unsigned  first;
      bit           found;
      page_rsp_type r;
      lim   = pages_in_use_range();
      run   = 0;
      start = 0;
      found = 1'b0;
      r.block_address = '0;
      r.status        = 1'b0;
      if (it.kind == KIND_ALLOC) begin
         if (it.count != 0) begin
            for (p = 1; p < lim; p++) begin
               if (page_used[p]) begin
                  run = 0;
               end else begin
                  if (run == 0) start = p;
                  run++;
                  if (run == it.count) begin
                     found = 1'b1;
                     break;
                  end
               end
            end
         end
         if (found) begin
            for (p = start; p < start + it.count; p++) page_used[p] = 1'b1;
            r.block_address = ADDR_W'(start << PAGE_SHIFT);
         end else begin
            r.status = 1'b1;
         end
      end else if (it.kind == KIND_FREE || it.kind == KIND_RESERVE) begin
         first = 32'(it.addr >> PAGE_SHIFT);
         for (p = first; p < first + it.count; p++) begin
            if (p >= lim) break;
            page_used[p] = (it.kind == KIND_RESERVE);
         end
      end
      return r;
   endfunction

   task automatic write_pages_present(logic [CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid       <= 1'b0;
      pages_present_q  = value;
   endtask

   task automatic offer_item(page_req_type it, bit typed, page_rsp_type typed_rsp,
                             bit drain_first);
      page_rsp_type pred;
      if (drain_first || ($urandom_range(99) < sender_idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         if (drain_first) while (pending_rsp_q.size() != 0) @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_tdata  <= {{(REQ_TDATA_W-ADDR_W-COUNT_W){1'b0}}, it.count, it.addr};
      req_tuser  <= it.kind;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_page_op(it);
      pending_rsp_q.push_back(typed ? typed_rsp : pred);
      if (it.kind == KIND_ALLOC && pred.status == 1'b0) begin
         it.addr = pred.block_address;
         live_blocks_q.push_back(it);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (pending_rsp_q.size() == 0) begin
            if (mismatch_count < REPORT_MAX)
               $display("ERROR: result %0d with nothing pending: block_address %h status %0d",
                        result_count, rsp_tdata[ADDR_W-1:0], rsp_tuser[0]);
            mismatch_count++;
         end else begin
            got_want = pending_rsp_q.pop_front();
            if (rsp_tdata[ADDR_W-1:0] !== got_want.block_address ||
                rsp_tuser[0] !== got_want.status) begin
               if (mismatch_count < REPORT_MAX)
                  $display("ERROR: result %0d: block_address exp %h got %h, status exp %0d got %0d",
                           result_count, got_want.block_address, rsp_tdata[ADDR_W-1:0],
                           got_want.status, rsp_tuser[0]);
               mismatch_count++;
            end
         end
      end
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      #500_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      page_req_type     item;
      page_rsp_type     want;
      page_req_type     victim;
      logic [CFG_W-1:0] cfg;
      logic [31:0]      rnd;
      int unsigned      phase;
      int unsigned      n;
      int unsigned      lim;
      int unsigned      span;
      int unsigned      pg;
      int unsigned      pick;
      int unsigned      idx;

      for (int i = 0; i < PAGE_TOTAL; i++) page_used[i] = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].what == ROW_CFG) begin
            write_pages_present(directed_rows[r].cfg);
         end else begin
            item.kind          = directed_rows[r].kind;
            item.addr          = directed_rows[r].addr;
            item.count         = directed_rows[r].count;
            want.block_address = directed_rows[r].exp_addr;
            want.status        = directed_rows[r].exp_status;
            offer_item(item, directed_rows[r].what == ROW_TYPED, want, 1'b0);
         end
      end

      want.block_address = '0;
      want.status        = 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       cfg = 16'hFFFF;
            5:       cfg = 16'd32768;
            9:       cfg = 16'd0;
            12:      cfg = 16'd1;
            default: cfg = CFG_W'($urandom_range(2, 1100));
         endcase
         write_pages_present(cfg);
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 60;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 60;
            end
            default: begin
               sender_idle_pct    = 14;
               receiver_stall_pct = 14;
            end
         endcase
         lim  = pages_in_use_range();
         span = (lim == 0) ? 1 : lim;

         // open up the whole range so allocations get past the first pages
         if (lim != 0 && (phase == 0 || $urandom_range(1) == 0)) begin
            live_blocks_q.delete();
            item.kind  = KIND_FREE;
            item.addr  = '0;
            item.count = COUNT_W'(lim);
            offer_item(item, 1'b0, want, 1'b0);
         end

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 4 && n == 20) hold_request = 400;
            pick = $urandom_range(99);
            rnd  = $urandom;
            item.addr = rnd[ADDR_W-1:0];
            if (pick < 45) begin
               item.kind  = KIND_ALLOC;
               item.count = COUNT_W'($urandom_range(1, ($urandom_range(9) == 0) ? 64 : 8));
            end else if (pick < 75 && live_blocks_q.size() != 0) begin
               idx    = $urandom_range(live_blocks_q.size() - 1);
               victim = live_blocks_q[idx];
               live_blocks_q.delete(idx);
               item.kind  = KIND_FREE;
               item.addr  = victim.addr;
               item.count = victim.count;
               if ($urandom_range(1) == 0)
                  item.addr = item.addr | ADDR_W'($urandom_range(BYTES_PER_PAGE - 1));
            end else if (pick < 87) begin
               item.kind = ($urandom_range(1) == 0) ? KIND_RESERVE : KIND_FREE;
               pg = $urandom_range(span + 8);
               if (pg > PAGE_TOTAL - 1) pg = PAGE_TOTAL - 1;
               item.addr  = ADDR_W'(pg << PAGE_SHIFT) |
                            ADDR_W'($urandom_range(BYTES_PER_PAGE - 1));
               item.count = COUNT_W'($urandom_range(32));
            end else begin
               item.kind = KIND_W'($urandom_range(3));
               rnd       = $urandom;
               item.count = ($urandom_range(3) == 0) ? rnd[COUNT_W-1:0]
                                                     : COUNT_W'($urandom_range(4));
            end
            offer_item(item, 1'b0, want, phase == 4 && n == 60);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
